FILE: rtl/core/permutation_next_compose_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation engine
// Checks compile in simulation and vanish when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_NEXT_COMPOSE_ENGINE_TOP_DEFINES_SVH
`define PERMUTATION_NEXT_COMPOSE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PNCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pnce assertion failed");
// expression must never be true outside reset
`define PNCE_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pnce forbidden condition seen");
`else
`define PNCE_ASSERT(label, clk, rst_n, prop)
`define PNCE_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/pnce_pkg.sv
// ----------------------------------------------------------------------------
// pnce_pkg
// Shared types, sizes and helpers for the permutation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pnce_pkg;

    // permutation size and field widths
    localparam int N_ENTRIES    = 8;
    localparam int IDX_W        = (N_ENTRIES > 1) ? $clog2(N_ENTRIES) : 1;
    localparam int ENT_W        = 4;
    localparam int POS_W        = 3;
    localparam int PACKED_SLOTS = 8;
    localparam int WORD_W       = ENT_W * PACKED_SLOTS;

    // command codes; the fourth code leaves the state alone
    typedef enum logic [1:0] {
        FUNC_NEXT    = 2'd0,
        FUNC_SWAP    = 2'd1,
        FUNC_COMPOSE = 2'd2
    } t_func;

    typedef logic [N_ENTRIES-1:0][ENT_W-1:0] t_perm;

    // input beat
    typedef struct packed {
        t_func             func;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [WORD_W-1:0] other_perm;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [WORD_W-1:0] perm_out;
        logic              wrapped;
        logic              bad_operand;
    } t_out_beat;

    // what one lane reports to the merge stage
    typedef struct packed {
        logic                 asc;       // entry below its right neighbor
        logic                 op_ok;     // operand entry in range
        logic [N_ENTRIES-1:0] op_hot;    // operand entry, one-hot
    } t_find;

    // merged decisions broadcast back to the lanes
    typedef struct packed {
        logic             has_pivot;
        logic [IDX_W-1:0] pivot;
        logic [IDX_W-1:0] succ;
        logic             op_valid;
    } t_ctrl;

    function automatic t_perm f_identity();
        t_perm p;
        for (int i = 0; i < N_ENTRIES; i++) begin
            p[i] = ENT_W'(i);
        end
        return p;
    endfunction

    // entries 0..7 as nibbles, zero above N_ENTRIES
    function automatic logic [WORD_W-1:0] f_pack(input t_perm p);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int s = 0; s < PACKED_SLOTS; s++) begin
            if (s < N_ENTRIES) begin
                w[s*ENT_W +: ENT_W] = p[s];
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pnce_lane.sv
// ----------------------------------------------------------------------------
// pnce_lane
// One position of the permutation: reports local findings and builds the
// new entry for its position from the merged decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module pnce_lane
    import pnce_pkg::*;
(
    input  wire logic [IDX_W-1:0] i_lane,
    input  wire t_perm            i_state,
    input  wire t_in_beat         i_cmd,
    input  wire t_ctrl            i_ctrl,
    output t_find                 o_find,
    output logic [ENT_W-1:0]      o_entry
);

    localparam logic [IDX_W:0] N_EXT = (IDX_W+1)'(N_ENTRIES);

    logic [ENT_W-1:0] op_nib;
    logic [IDX_W:0]   rev_src;
    logic [IDX_W-1:0] rev_idx;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             swap_ok;

    // operand entry for this lane; identity beyond the packed slots
    always_comb begin
        if ({1'b0, i_lane} < (IDX_W+1)'(PACKED_SLOTS)) begin
            op_nib = ENT_W'(i_cmd.other_perm >> (ENT_W * int'(i_lane)));
        end else begin
            op_nib = ENT_W'(i_lane);
        end
    end

    // findings: ascent with right neighbor, operand range and one-hot
    always_comb begin
        o_find = '0;
        if ({1'b0, i_lane} < N_EXT - (IDX_W+1)'(1)) begin
            o_find.asc = i_state[i_lane] < i_state[IDX_W'(i_lane + 1'b1)];
        end
        o_find.op_ok = {1'b0, op_nib} < (ENT_W+1)'(N_ENTRIES);
        if (o_find.op_ok) begin
            o_find.op_hot = N_ENTRIES'(1) << op_nib;
        end
    end

    // suffix after the pivot is read back in reverse order
    assign rev_src = N_EXT + {1'b0, i_ctrl.pivot} - {1'b0, i_lane};
    assign rev_idx = rev_src[IDX_W-1:0];

    assign swap_ok = ({1'b0, i_cmd.pos_a} < (POS_W+1)'(N_ENTRIES))
                  && ({1'b0, i_cmd.pos_b} < (POS_W+1)'(N_ENTRIES));
    assign idx_a   = IDX_W'(i_cmd.pos_a);
    assign idx_b   = IDX_W'(i_cmd.pos_b);

    // new entry for this position
    always_comb begin
        o_entry = i_state[i_lane];
        unique case (i_cmd.func)
            FUNC_NEXT: begin
                if (!i_ctrl.has_pivot) begin
                    o_entry = ENT_W'(i_lane);
                end else if (i_lane == i_ctrl.pivot) begin
                    o_entry = i_state[i_ctrl.succ];
                end else if (i_lane > i_ctrl.pivot) begin
                    if (rev_idx == i_ctrl.succ) begin
                        o_entry = i_state[i_ctrl.pivot];
                    end else begin
                        o_entry = i_state[rev_idx];
                    end
                end
            end
            FUNC_SWAP: begin
                if (swap_ok) begin
                    if (i_lane == idx_a) begin
                        o_entry = i_state[idx_b];
                    end else if (i_lane == idx_b) begin
                        o_entry = i_state[idx_a];
                    end
                end
            end
            FUNC_COMPOSE: begin
                if (i_ctrl.op_valid) begin
                    o_entry = i_state[IDX_W'(op_nib)];
                end
            end
            default: begin
                o_entry = i_state[i_lane];
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pnce_merge.sv
// ----------------------------------------------------------------------------
// pnce_merge
// Combines the lane findings: pivot and successor for the next step, and
// the validity of a compose operand.
// ----------------------------------------------------------------------------
`default_nettype none

module pnce_merge
    import pnce_pkg::*;
(
    input  wire t_perm                 i_state,
    input  wire t_find [N_ENTRIES-1:0] i_find,
    output t_ctrl                      o_ctrl
);

    logic [ENT_W-1:0]     pivot_val;
    logic [N_ENTRIES-1:0] seen;
    logic                 all_ok;

    // pivot: rightmost ascent
    always_comb begin
        o_ctrl.has_pivot = 1'b0;
        o_ctrl.pivot     = '0;
        for (int m = 0; m < N_ENTRIES; m++) begin
            if (i_find[m].asc) begin
                o_ctrl.has_pivot = 1'b1;
                o_ctrl.pivot     = IDX_W'(m);
            end
        end
    end

    assign pivot_val = i_state[o_ctrl.pivot];

    // successor: rightmost entry past the pivot that is larger than it
    always_comb begin
        o_ctrl.succ = '0;
        for (int m = 0; m < N_ENTRIES; m++) begin
            if ((IDX_W'(m) > o_ctrl.pivot) && (i_state[m] > pivot_val)) begin
                o_ctrl.succ = IDX_W'(m);
            end
        end
    end

    // operand is a permutation when all entries are in range and cover all
    always_comb begin
        seen   = '0;
        all_ok = 1'b1;
        for (int m = 0; m < N_ENTRIES; m++) begin
            seen   = seen | i_find[m].op_hot;
            all_ok = all_ok & i_find[m].op_ok;
        end
        o_ctrl.op_valid = all_ok && (&seen);
    end

endmodule

`default_nettype wire

FILE: rtl/core/permutation_next_compose_engine_top.sv
// ----------------------------------------------------------------------------
// permutation_next_compose_engine_top
// Holds a permutation and applies next / swap / compose commands to it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one command
//   beat: func, swap positions and a packed compose operand.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one beat
//   per command: the packed permutation after the command plus the wrap
//   and bad-operand flags.
//   The state updates at the accepting edge and the result beat is valid
//   on the next cycle.
//   One command is accepted per cycle while results are taken; the lanes and
//   the merge network are combinational, so only the receiver stalls beats.
//   The output register frees itself in the cycle it is taken, so a new
//   command is accepted while the previous result is leaving.
//   When the receiver stalls, the result holds and o_in_ready drops until
//   the pending beat is taken.
//   Synchronous reset loads the identity permutation and empties the
//   output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permutation_next_compose_engine_top_defines.svh"

module permutation_next_compose_engine_top
    import pnce_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_data
);

    t_perm                 r_state;
    t_perm                 n_state;
    t_out_beat             r_out;
    logic                  r_out_valid;
    t_find [N_ENTRIES-1:0] lane_find;
    t_ctrl                 ctrl;
    logic                  in_fire;
    logic                  wrap_flag;
    logic                  bad_flag;

    // lanes, one per position
    for (genvar g = 0; g < N_ENTRIES; g++) begin : g_lane
        pnce_lane u_lane (
            .i_lane  (IDX_W'(g)),
            .i_state (r_state),
            .i_cmd   (i_in_data),
            .i_ctrl  (ctrl),
            .o_find  (lane_find[g]),
            .o_entry (n_state[g])
        );
    end

    pnce_merge u_merge (
        .i_state (r_state),
        .i_find  (lane_find),
        .o_ctrl  (ctrl)
    );

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign wrap_flag = (i_in_data.func == FUNC_NEXT) && !ctrl.has_pivot;
    assign bad_flag  = (i_in_data.func == FUNC_COMPOSE) && !ctrl.op_valid;

    // state and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= f_identity();
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.perm_out    <= f_pack(n_state);
            r_out.wrapped     <= wrap_flag;
            r_out.bad_operand <= bad_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `PNCE_NEVER(a_flags_exclusive, i_clk, i_rst_n,
        r_out_valid && r_out.wrapped && r_out.bad_operand)
    `PNCE_ASSERT(a_fire_gives_beat, i_clk, i_rst_n, in_fire |=> r_out_valid)
    `PNCE_ASSERT(a_wrap_is_identity, i_clk, i_rst_n,
        (r_out_valid && r_out.wrapped) |-> (r_state == f_identity()))
    `PNCE_ASSERT(a_bad_keeps_state, i_clk, i_rst_n,
        (in_fire && bad_flag) |=> (r_state == $past(r_state)))

endmodule

`default_nettype wire

FILE: sim/perm_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perm_check_pkg
// Scoreboard for the permutation engine. It keeps its own copy of the
// permutation, works out the result beat for every accepted command and
// checks the beats that come back, oldest first.
// ----------------------------------------------------------------------------
package perm_check_pkg;

    import pnce_pkg::*;

    class perm_scoreboard;

        t_perm     state;
        t_out_beat expected_q[$];
        int        n_errors;
        int        n_checked;

        function new();
            for (int i = 0; i < N_ENTRIES; i++) begin
                state[i] = ENT_W'(i);
            end
            n_errors  = 0;
            n_checked = 0;
        endfunction

        // one line per problem, counted
        function void report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            n_errors++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // entries 0..7 as nibbles, entry 0 lowest
        function logic [WORD_W-1:0] pack_entries(t_perm p);
            logic [WORD_W-1:0] w;
            w = '0;
            for (int s = 0; s < PACKED_SLOTS; s++) begin
                if (s < N_ENTRIES) begin
                    w[s*ENT_W +: ENT_W] = p[s];
                end
            end
            return w;
        endfunction

        // lexicographic successor in place; 0 when state is the last one
        function bit advance();
            int               j;
            int               k;
            int               lo;
            int               hi;
            logic [ENT_W-1:0] t;
            j = N_ENTRIES - 2;
            while (j >= 0 && state[j] >= state[j+1]) begin
                j--;
            end
            if (j < 0) begin
                return 1'b0;
            end
            k = N_ENTRIES - 1;
            while (k > j && state[k] <= state[j]) begin
                k--;
            end
            t        = state[j];
            state[j] = state[k];
            state[k] = t;
            lo = j + 1;
            hi = N_ENTRIES - 1;
            while (lo < hi) begin
                t         = state[lo];
                state[lo] = state[hi];
                state[hi] = t;
                lo++;
                hi--;
            end
            return 1'b1;
        endfunction

        // state[i] <= state[operand[i]]; 0 and no change on a bad operand
        function bit apply_operand(logic [WORD_W-1:0] w);
            t_perm operand;
            t_perm result;
            bit    seen [N_ENTRIES];
            int    v;
            foreach (seen[i]) begin
                seen[i] = 1'b0;
            end
            for (int i = 0; i < N_ENTRIES; i++) begin
                v = (i < PACKED_SLOTS) ? int'(w[i*ENT_W +: ENT_W]) : i;
                if (v >= N_ENTRIES || seen[v]) begin
                    return 1'b0;
                end
                seen[v]    = 1'b1;
                operand[i] = ENT_W'(v);
            end
            for (int i = 0; i < N_ENTRIES; i++) begin
                result[i] = state[operand[i]];
            end
            state = result;
            return 1'b1;
        endfunction

        // accepted command beat: update the state, queue the result beat
        function void note_command(t_in_beat cmd);
            t_out_beat want;
            want = '0;
            case (cmd.func)
                FUNC_NEXT: begin
                    if (!advance()) begin
                        for (int i = 0; i < N_ENTRIES; i++) begin
                            state[i] = ENT_W'(i);
                        end
                        want.wrapped = 1'b1;
                    end
                end
                FUNC_SWAP: begin
                    logic [ENT_W-1:0] t;
                    if (cmd.pos_a < N_ENTRIES && cmd.pos_b < N_ENTRIES) begin
                        t                = state[cmd.pos_a];
                        state[cmd.pos_a] = state[cmd.pos_b];
                        state[cmd.pos_b] = t;
                    end
                end
                FUNC_COMPOSE: begin
                    want.bad_operand = !apply_operand(cmd.other_perm);
                end
                default: begin
                    // unused code: nothing moves
                end
            endcase
            want.perm_out = pack_entries(state);
            expected_q.push_back(want);
        endfunction

        // result beat taken from the block
        function void check_result(t_out_beat got);
            t_out_beat want;
            n_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d with nothing expected, perm %h",
                                 n_checked, got.perm_out));
                return;
            end
            want = expected_q.pop_front();
            if (got.perm_out !== want.perm_out) begin
                report($sformatf("result %0d perm_out %h, want %h",
                                 n_checked, got.perm_out, want.perm_out));
            end
            if (got.wrapped !== want.wrapped) begin
                report($sformatf("result %0d wrapped %b, want %b",
                                 n_checked, got.wrapped, want.wrapped));
            end
            if (got.bad_operand !== want.bad_operand) begin
                report($sformatf("result %0d bad_operand %b, want %b",
                                 n_checked, got.bad_operand, want.bad_operand));
            end
        endfunction

    endclass

endpackage

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the permutation engine. A directed opening covers next,
// swap, compose, the wrap from the last permutation, bad operands and the
// unused command code; random command sequences follow, mostly runs of next,
// swaps, valid composes and walks up to the last permutation. Both sides
// idle at random, the receiver holds off long enough to back the block up,
// and every result beat is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import pnce_pkg::*;
    import perm_check_pkg::*;

    localparam logic [1:0] NOP_CODE    = 2'd3;
    localparam int         N_COMMANDS  = 1200;
    localparam int         HOLD_CYCLES = 64;
    localparam int         TAIL_CYCLES = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_data;

    perm_scoreboard sb = new();
    bit             steady = 1'b0;   // no random gaps on either side while set
    int             n_cmds = 0;

    permutation_next_compose_engine_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // hard stop
    initial begin
        #2_000_000;
        $display("permutation_next_compose_engine_top regression: fail");
        $finish;
    end

    // offer one command beat after a random gap, return once it is taken
    task automatic send_beat(input t_func f, input logic [POS_W-1:0] a,
                             input logic [POS_W-1:0] b, input logic [WORD_W-1:0] w);
        t_in_beat cmd;
        int       gap;
        cmd.func       = f;
        cmd.pos_a      = a;
        cmd.pos_b      = b;
        cmd.other_perm = w;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= cmd;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd);
        if (f != t_func'(NOP_CODE)) begin
            n_cmds++;
        end
    endtask

    // stop offering until every queued result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [WORD_W-1:0] shuffled_word();
        t_perm            p;
        int               k;
        logic [ENT_W-1:0] t;
        for (int i = 0; i < N_ENTRIES; i++) begin
            p[i] = ENT_W'(i);
        end
        for (int i = N_ENTRIES - 1; i > 0; i--) begin
            k    = $urandom_range(0, i);
            t    = p[i];
            p[i] = p[k];
            p[k] = t;
        end
        return sb.pack_entries(p);
    endfunction

    // operand that turns the current state into the last (descending) one
    function automatic logic [WORD_W-1:0] descending_word();
        t_perm q;
        q = '0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            for (int j = 0; j < N_ENTRIES; j++) begin
                if (sb.state[j] == ENT_W'(N_ENTRIES - 1 - i)) begin
                    q[i] = ENT_W'(j);
                end
            end
        end
        return sb.pack_entries(q);
    endfunction

    // result side: random stalls, two long hold-offs
    initial begin : receiver
        int wait_cnt;
        int hold_cnt;
        int n_taken;
        wait_cnt = 0;
        hold_cnt = 0;
        n_taken  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_out_valid && i_out_ready) begin
                    sb.check_result(o_out_data);
                    n_taken++;
                    if (n_taken == 300 || n_taken == 900) begin
                        hold_cnt = HOLD_CYCLES;
                    end
                    wait_cnt = steady ? 0 : $urandom_range(0, 7);
                end else if (o_out_valid && wait_cnt > 0 && hold_cnt == 0) begin
                    wait_cnt--;
                end
                if (hold_cnt > 0) begin
                    hold_cnt--;
                end
                i_out_ready <= (wait_cnt == 0) && (hold_cnt == 0);
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [WORD_W-1:0] w;
        int                pick;
        int                slot;
        int                run_len;
        bit                paused;
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening
        send_beat(FUNC_NEXT, 3'd0, 3'd0, 32'h0);
        send_beat(FUNC_NEXT, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_beat(FUNC_SWAP, 3'd0, 3'd7, 32'h0);
        send_beat(FUNC_SWAP, 3'd3, 3'd3, 32'h0);           // swap with itself
        send_beat(FUNC_SWAP, 3'd7, 3'd0, 32'hFFFF_FFFF);
        send_beat(t_func'(NOP_CODE), 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, 32'h7654_3210); // identity operand
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, 32'h0123_4567); // reversal
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, 32'hFFFF_FFFF); // entries out of range
        send_beat(FUNC_COMPOSE, 3'd7, 3'd7, 32'h0000_0000); // repeated entries
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, 32'h7654_3218); // one entry of 8
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, 32'h7654_3211); // one repeat
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, descending_word());
        send_beat(FUNC_NEXT, 3'd0, 3'd0, 32'h0);            // wraps
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, descending_word());
        send_beat(FUNC_SWAP, 3'd6, 3'd7, 32'h0);            // one before the last
        send_beat(FUNC_NEXT, 3'd0, 3'd0, 32'h0);
        send_beat(FUNC_NEXT, 3'd0, 3'd0, 32'h0);            // wraps again
        send_beat(FUNC_COMPOSE, 3'd0, 3'd0, shuffled_word());
        send_beat(FUNC_NEXT, 3'd0, 3'd0, 32'h0);
        send_beat(t_func'(NOP_CODE), 3'd0, 3'd0, 32'h0);
        drain_results();

        // random command sequences
        while (n_cmds < N_COMMANDS) begin
            steady = (n_cmds >= 200 && n_cmds < 300) || (n_cmds >= 700 && n_cmds < 780);
            if (!paused && n_cmds >= 600) begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                // run of next
                run_len = $urandom_range(1, 8);
                repeat (run_len) begin
                    send_beat(FUNC_NEXT, 3'($urandom), 3'($urandom), $urandom);
                end
            end else if (pick < 53) begin
                send_beat(FUNC_SWAP, 3'($urandom), 3'($urandom), $urandom);
            end else if (pick < 68) begin
                send_beat(FUNC_COMPOSE, 3'($urandom), 3'($urandom), shuffled_word());
            end else if (pick < 76) begin
                // walk to the last permutation, maybe swap two neighbors, then step on with next
                send_beat(FUNC_COMPOSE, 3'($urandom), 3'($urandom), descending_word());
                if ($urandom_range(0, 1) == 1) begin
                    slot = $urandom_range(0, N_ENTRIES - 2);
                    send_beat(FUNC_SWAP, 3'(slot), 3'(slot + 1), $urandom);
                    send_beat(FUNC_NEXT, 3'($urandom), 3'($urandom), $urandom);
                end
                send_beat(FUNC_NEXT, 3'($urandom), 3'($urandom), $urandom);
                send_beat(FUNC_NEXT, 3'($urandom), 3'($urandom), $urandom);
            end else if (pick < 88) begin
                // broken operand: raw word, an entry of 8 and up, or a repeat
                w    = shuffled_word();
                slot = $urandom_range(0, PACKED_SLOTS - 1);
                case ($urandom_range(0, 2))
                    0: w = $urandom;
                    1: w[slot*ENT_W +: ENT_W] = ENT_W'($urandom_range(N_ENTRIES, 15));
                    default: w[slot*ENT_W +: ENT_W] =
                                 w[((slot + 1) % PACKED_SLOTS)*ENT_W +: ENT_W];
                endcase
                send_beat(FUNC_COMPOSE, 3'($urandom), 3'($urandom), w);
            end else if (pick < 94) begin
                send_beat(t_func'(NOP_CODE), 3'($urandom), 3'($urandom), $urandom);
            end else begin
                send_beat(t_func'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                          $urandom);
            end
        end
        steady = 1'b0;

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("permutation_next_compose_engine_top regression: pass");
        end else begin
            $display("permutation_next_compose_engine_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pnce_pkg.sv
rtl/core/pnce_lane.sv
rtl/core/pnce_merge.sv
rtl/core/permutation_next_compose_engine_top.sv
sim/perm_check_pkg.sv
sim/testbench.sv
